[design/frfc_pkg.sv]
`timescale 1ns / 1ps

package frfc_pkg;

  // Command codes carried on tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Fixed field widths
  localparam int IDX_W  = 6;
  localparam int FLD_W  = 16;
  localparam int CNT_W  = 7;
  localparam int EXTRA_W = 20;
  // Width that holds every size, count and request total without overflow
  localparam int CW     = 33;
  // Fraction point of extra_fraction (Q4.12)
  localparam int FRAC_W = 12;

  // Packed input tdata layout, lowest bit first
  localparam int S_TDATA_W   = 72;
  localparam int OFS_IDX     = 0;
  localparam int OFS_RSIZE   = 6;
  localparam int OFS_REQSIZE = 22;
  localparam int OFS_REQCNT  = 38;
  localparam int OFS_FRAC    = 54;
  localparam int M_TDATA_W   = 8;

  // Running chunk count saturates one above any request count
  localparam int CHUNK_W = 17;
  localparam logic [CHUNK_W-1:0] COUNT_SAT = 17'h10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_POST,
    ST_DECIDE,
    ST_FINISH
  } state_t;

endpackage

[design/frfc_mul.sv]
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle
module frfc_mul
  import frfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [FLD_W-1:0]   a,
  input  logic [FLD_W-1:0]   b,
  output logic               busy,
  output logic [2*FLD_W-1:0] product
);

  localparam int CNTW = $clog2(FLD_W + 1);

  logic [CNTW-1:0]  cnt;
  logic [FLD_W-1:0] mcand;
  logic [FLD_W-1:0] hi;
  logic [FLD_W-1:0] lo;
  logic [FLD_W:0]   sum;

  assign busy    = (cnt != '0);
  assign product = {hi, lo};

  // partial sum for the current multiplier bit
  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(FLD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[FLD_W:1];
      lo <= {sum[0], lo[FLD_W-1:1]};
    end
  end

endmodule

[design/frfc_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module frfc_div
  import frfc_pkg::*;
#(
  parameter int N = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [N-1:0]     dividend,
  input  logic [FLD_W-1:0] divisor,
  output logic             busy,
  output logic [N-1:0]     quotient,
  output logic [FLD_W-1:0] remainder
);

  localparam int CNTW = $clog2(N + 1);

  logic [CNTW-1:0]  cnt;
  logic [FLD_W-1:0] dvs;
  logic [FLD_W-1:0] rem;
  logic [N-1:0]     quo;
  logic [FLD_W:0]   trial;
  logic [FLD_W:0]   diff;
  logic             ge;

  assign busy      = (cnt != '0);
  assign quotient  = quo;
  assign remainder = rem;

  // trial subtract of the next partial remainder
  always_comb begin
    trial = {rem, quo[N-1]};
    ge    = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[FLD_W-1:0] : trial[FLD_W-1:0];
      quo <= {quo[N-2:0], ge};
    end
  end

endmodule

[design/frfc_table.sv]
`timescale 1ns / 1ps

// Region size table, one write and one registered read port
module frfc_table
  import frfc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/free_region_fit_check.sv]
`timescale 1ns / 1ps

// Channel  Dir  Signals                          Contents
// s        in   s_tvalid s_tready s_tdata        region/request fields
//               s_tuser s_tlast                  cmd, region_last
// m        out  m_tvalid m_tready m_tdata        available, queries only
//
// A load writes the table directly. A query runs the two shift-add multiplies
// together, then walks the regions in order, starting the serial divider on a
// region whenever at least one request_size chunk fits in it.
// Synchronous active-high reset clears the region count and all control.
// A result waits in the output register; loads are still taken meanwhile.
module free_region_fit_check
  import frfc_pkg::*;
#(
  parameter int MAX_REGIONS = 64,
  parameter int SIZE_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // region_index, region_size, request_size, request_count, extra_fraction
  input  logic [S_TDATA_W-1:0] s_tdata,
  // cmd
  input  logic                 s_tuser,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // available
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  state_t state, state_next;

  logic [CNT_W-1:0]   region_count;
  logic [CNT_W-1:0]   idx;
  logic [FLD_W-1:0]   req_size;
  logic [FLD_W-1:0]   req_count;
  logic [EXTRA_W-1:0] extra;
  logic [CW-1:0]      need_all;
  logic [CHUNK_W-1:0] chunks;
  logic               have_extra;
  logic               result;
  logic               out_valid;
  logic               out_data;

  // handshake and field taps
  logic               s_acc;
  logic [IDX_W-1:0]   in_idx;
  logic               load_ok;

  // control from the sequencer
  logic mul_start, div_start, rd_en, finish_set, finish_val, go_next, take_extra;

  // unit results
  logic               mul_ext_busy, mul_all_busy;
  logic [2*FLD_W-1:0] prod_ext, prod_all;
  logic               div_busy;
  logic [SIZE_BITS-1:0] div_quo;
  logic [FLD_W-1:0]   div_rem;
  logic [SIZE_BITS-1:0] rd_data;

  // compares against the current region
  logic [CW-1:0] r_w, size_w, extra_w, chunk_sum;
  logic          hit_all, can_chunk, fits_extra, last_region;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign in_idx   = s_tdata[OFS_IDX +: IDX_W];
  assign load_ok  = s_acc && (s_tuser == CMD_LOAD) && (32'(in_idx) < MAX_REGIONS);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, out_data};

  assign r_w         = CW'(rd_data);
  assign size_w      = CW'(req_size);
  assign extra_w     = CW'(extra);
  assign hit_all     = (r_w >= need_all);
  assign can_chunk   = (req_size != '0) && (r_w >= size_w);
  assign fits_extra  = (r_w >= extra_w);
  assign last_region = ((idx + 1'b1) == region_count);
  assign chunk_sum   = CW'(chunks) + CW'(div_quo);

  // extra piece and chunk totals
  frfc_mul u_mul_ext (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (s_tdata[OFS_REQSIZE +: FLD_W]),
    .b       (s_tdata[OFS_FRAC +: FLD_W]),
    .busy    (mul_ext_busy),
    .product (prod_ext)
  );

  frfc_mul u_mul_all (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (s_tdata[OFS_REQSIZE +: FLD_W]),
    .b       (s_tdata[OFS_REQCNT +: FLD_W]),
    .busy    (mul_all_busy),
    .product (prod_all)
  );

  frfc_div #(
    .N (SIZE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rd_data),
    .divisor   (req_size),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  frfc_table #(
    .DEPTH (MAX_REGIONS),
    .AW    (AW),
    .WIDTH (SIZE_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (AW'(in_idx)),
    .wr_data (SIZE_BITS'(s_tdata[OFS_RSIZE +: FLD_W])),
    .rd_en   (rd_en),
    .rd_addr (AW'(idx)),
    .rd_data (rd_data)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and controls
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    finish_set = 1'b0;
    finish_val = 1'b0;
    go_next    = 1'b0;
    take_extra = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_acc && (s_tuser == CMD_QUERY)) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!mul_ext_busy && !mul_all_busy) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (region_count == '0) begin
          finish_set = 1'b1;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit_all) begin
          finish_set = 1'b1;
          finish_val = 1'b1;
        end else if (can_chunk) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (fits_extra && (CHUNK_W'(req_count) <= chunks)) begin
          finish_set = 1'b1;
          finish_val = 1'b1;
        end else begin
          take_extra = fits_extra;
          go_next    = 1'b1;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if ((chunks > CHUNK_W'(req_count)) ||
            ((chunks == CHUNK_W'(req_count)) && have_extra)) begin
          finish_set = 1'b1;
          finish_val = 1'b1;
        end else begin
          go_next = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // advance to the next region or give up after the last one
    if (go_next) begin
      if (last_region) begin
        finish_set = 1'b1;
      end else begin
        state_next = ST_READ;
      end
    end
    if (finish_set) begin
      state_next = ST_FINISH;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (load_ok && s_tlast) begin
        region_count <= CNT_W'(in_idx) + 1'b1;
      end
      if ((state == ST_FINISH) && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (mul_start) begin
      req_size  <= s_tdata[OFS_REQSIZE +: FLD_W];
      req_count <= s_tdata[OFS_REQCNT +: FLD_W];
    end
    if (state == ST_SUM) begin
      extra      <= prod_ext[2*FLD_W-1:FRAC_W];
      need_all   <= CW'(prod_all) + CW'(prod_ext[2*FLD_W-1:FRAC_W]);
      chunks     <= '0;
      have_extra <= 1'b0;
      idx        <= '0;
    end
    if (take_extra) begin
      have_extra <= 1'b1;
    end
    if (state == ST_POST) begin
      chunks <= (chunk_sum > CW'(COUNT_SAT)) ? COUNT_SAT : chunk_sum[CHUNK_W-1:0];
      if (CW'(div_rem) >= extra_w) begin
        have_extra <= 1'b1;
      end
    end
    if (go_next) begin
      idx <= idx + 1'b1;
    end
    if (finish_set) begin
      result <= finish_val;
    end
    if ((state == ST_FINISH) && (!out_valid || m_tready)) begin
      out_data <= result;
    end
  end

endmodule
